[rtl/core/predicate_pattern_histogram_assert.svh]
// Assertion helpers for the predicate pattern histogram.
`ifndef PREDICATE_PATTERN_HISTOGRAM_ASSERT_SVH
`define PREDICATE_PATTERN_HISTOGRAM_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PPH_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pph check failed");

// Consequent checked in the cycle after the antecedent.
`define PPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pph check failed");

`endif

[rtl/core/pph_pkg.sv]
package pph_pkg;

  localparam int PRED_MAX    = 6;
  localparam int COUNT_BITS  = 31;
  localparam int STORE_DEPTH = 1 << PRED_MAX;
  localparam int CFG_BITS    = 3;

  typedef logic [PRED_MAX-1:0]   pat_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [CFG_BITS-1:0]   cfg_t;

  localparam cnt_t ROW_LIMIT = '1;

  typedef enum logic {
    CMD_ROW  = 1'b0,
    CMD_DUMP = 1'b1
  } command_t;

  typedef struct packed {
    command_t command;
    pat_t     pred_true;
    pat_t     pred_defined;
  } cmd_word_t;

  typedef struct packed {
    pat_t pattern;
    cnt_t count;
    logic last;
    logic overflow;
  } bin_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROW,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic row_accept;
    logic row_commit;
    logic dump_start;
    logic dump_load;
  } dp_ctl_t;

  typedef struct packed {
    logic out_free;
    logic dump_last;
  } dp_stat_t;

  // Low mask over the predicates in use; count clamped to 1..PRED_MAX.
  function automatic pat_t eff_mask(cfg_t cnt);
    cfg_t n;
    pat_t m;
    n = cnt;
    if (n == '0) begin
      n = cfg_t'(1);
    end
    if (int'(n) > PRED_MAX) begin
      n = cfg_t'(PRED_MAX);
    end
    for (int i = 0; i < PRED_MAX; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

endpackage

[rtl/core/pph_ctrl.sv]
module pph_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  pph_pkg::command_t  command,
  output logic               cmd_stall,
  input  pph_pkg::dp_stat_t  stat,
  output pph_pkg::dp_ctl_t   ctl
);
  import pph_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = (command == CMD_DUMP) ? S_DUMP : S_ROW;
        end
      end
      S_ROW: begin
        state_next = S_IDLE;
      end
      S_DUMP: begin
        if (stat.out_free && stat.dump_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_stall = 1'b1;
    ctl       = '0;
    unique case (state)
      S_IDLE: begin
        cmd_stall      = 1'b0;
        ctl.row_accept = cmd_valid && (command == CMD_ROW);
        ctl.dump_start = cmd_valid && (command == CMD_DUMP);
      end
      S_ROW: begin
        ctl.row_commit = 1'b1;
      end
      S_DUMP: begin
        ctl.dump_load = stat.out_free;
      end
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

endmodule

[rtl/core/pph_datapath.sv]
module pph_datapath (
  input  logic               clk,
  input  logic               rst,
  input  pph_pkg::dp_ctl_t   ctl,
  output pph_pkg::dp_stat_t  stat,
  input  pph_pkg::cmd_word_t cmd_word,
  output logic               bin_valid,
  input  logic               bin_stall,
  output pph_pkg::bin_word_t bin_word,
  input  logic               cfg_valid,
  input  pph_pkg::cfg_t      cfg_data
);
  import pph_pkg::*;

  cnt_t mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_bits;

  cfg_t pred_count;
  cnt_t rd_data;
  logic rd_hit;
  pat_t row_addr;
  logic row_hit;
  cnt_t row_total;
  logic overflow;
  pat_t dump_addr;

  pat_t sel_mask;
  pat_t row_pat;
  logic at_limit;
  cnt_t cur;
  logic rd_en;
  pat_t rd_addr;
  logic wr_en;

  assign sel_mask = eff_mask(pred_count);
  assign row_pat  = cmd_word.pred_true & cmd_word.pred_defined & sel_mask;
  assign at_limit = (row_total == ROW_LIMIT);
  assign cur      = rd_hit ? rd_data : '0;
  assign wr_en    = ctl.row_commit && row_hit;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pat_t'(dump_addr - 1'b1);
    priority if (ctl.row_accept) begin
      rd_en   = 1'b1;
      rd_addr = row_pat;
    end else if (ctl.dump_start) begin
      rd_en   = 1'b1;
      rd_addr = sel_mask;
    end else if (ctl.dump_load) begin
      rd_en   = (dump_addr != '0);
    end
  end

  // counter store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[row_addr] <= cnt_t'(cur + 1'b1);
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_hit  <= valid_bits[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pred_count <= cfg_t'(1);
      valid_bits <= '0;
      row_total  <= '0;
      overflow   <= 1'b0;
      bin_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pred_count <= cfg_data;
      end
      if (wr_en) begin
        valid_bits[row_addr] <= 1'b1;
        row_total            <= cnt_t'(row_total + 1'b1);
      end
      if (ctl.row_accept && at_limit) begin
        overflow <= 1'b1;
      end
      if (ctl.dump_load && (dump_addr == '0)) begin
        valid_bits <= '0;
        row_total  <= '0;
        overflow   <= 1'b0;
      end
      if (ctl.dump_load) begin
        bin_valid <= 1'b1;
      end else if (!bin_stall) begin
        bin_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.row_accept) begin
      row_addr <= row_pat;
      row_hit  <= !at_limit;
    end
    if (ctl.dump_start) begin
      dump_addr <= sel_mask;
    end
    if (ctl.dump_load) begin
      bin_word.pattern  <= dump_addr;
      bin_word.count    <= cur;
      bin_word.last     <= (dump_addr == '0);
      bin_word.overflow <= overflow;
      if (dump_addr != '0) begin
        dump_addr <= pat_t'(dump_addr - 1'b1);
      end
    end
  end

  assign stat.out_free  = !bin_valid || !bin_stall;
  assign stat.dump_last = (dump_addr == '0);

endmodule

[rtl/core/predicate_pattern_histogram.sv]
// Predicate pattern histogram: each row word (command 0) ANDs pred_true with
// pred_defined, masks to the predicate_count predicates in use (0 reads as 1,
// above 6 as 6) and increments that pattern's 31-bit counter; once 2^31-1 rows
// are counted, further rows only set the sticky overflow flag. For a row, the
// counter is read from the counter store in the accept cycle and written back
// incremented in the next. After a readout word (command 1) is accepted, the
// block emits 2^n words, pattern 2^n-1 down to 0, at one word per cycle while
// bin_stall is low, paced by the store's one read per cycle; last marks
// pattern 0. The readout clears counters, row total and overflow at once
// through per-entry valid bits, so no clearing pass is needed after reset or
// readout. The output register holds the final readout word while the next
// command word is taken. cfg_ready is always high; write predicate_count
// only while the block is idle.
module predicate_pattern_histogram (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  pph_pkg::cmd_word_t cmd_word,
  output logic               bin_valid,
  input  logic               bin_stall,
  output pph_pkg::bin_word_t bin_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  pph_pkg::cfg_t      cfg_data
);
  import pph_pkg::*;

  `include "predicate_pattern_histogram_assert.svh"

  dp_ctl_t  ctl;
  dp_stat_t stat;
  logic     cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  pph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .command   (cmd_word.command),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  pph_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .cmd_word  (cmd_word),
    .bin_valid (bin_valid),
    .bin_stall (bin_stall),
    .bin_word  (bin_word),
    .cfg_valid (cfg_write),
    .cfg_data  (cfg_data)
  );

  `PPH_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd_valid && !cmd_stall, cmd_stall)
  `PPH_ASSERT_SAME(a_zero_is_last, clk, rst,
    bin_valid && (bin_word.pattern == '0), bin_word.last)
  `PPH_ASSERT_NEXT(a_dump_steps_down, clk, rst,
    bin_valid && !bin_stall && !bin_word.last,
    bin_valid && (bin_word.pattern == pat_t'($past(bin_word.pattern) - 1'b1)))
  `PPH_ASSERT_SAME(a_dump_holds_input, clk, rst,
    bin_valid && !bin_word.last, cmd_stall)

endmodule
